### rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the divider and reload timer
// Register addresses, opcodes, sequencer states and the counter step record.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    localparam logic [7:0] TAC_READ_BASE = 8'hF8;
    localparam logic [7:0] UNMAPPED_READ = 8'hFF;
    localparam int unsigned TAC_ENABLE_POS = 2;

    localparam int unsigned CACC_W = 11;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic                ge;
        logic                wrap;
        logic [CACC_W-1:0]   cacc_next;
        logic [7:0]          counter_next;
    } t_step;

    function automatic logic [CACC_W-1:0] rate_period(input logic [1:0] sel);
        logic [CACC_W-1:0] p;
        begin
            unique case (sel)
                2'd0:    p = CACC_W'(256 * 4);
                2'd1:    p = CACC_W'(4 * 4);
                2'd2:    p = CACC_W'(16 * 4);
                default: p = CACC_W'(64 * 4);
            endcase
            return p;
        end
    endfunction

endpackage

### rtl/drt_step.sv
// ----------------------------------------------------------------------------
// drt_step: counter step unit
// Compares the prescale accumulator with the period, subtracts one period and
// advances the counter by one step with reload on wrap.
// ----------------------------------------------------------------------------
module drt_step (
    input  logic [drt_pkg::CACC_W-1:0] i_cacc,
    input  logic [drt_pkg::CACC_W-1:0] i_period,
    input  logic [7:0]                 i_counter,
    input  logic [7:0]                 i_reload,
    output drt_pkg::t_step             o_step
);
    import drt_pkg::*;

    always_comb begin
        o_step.ge           = (i_cacc >= i_period);
        o_step.cacc_next    = i_cacc - i_period;
        o_step.wrap         = (i_counter == 8'hFF);
        o_step.counter_next = o_step.wrap ? i_reload : (i_counter + 8'd1);
    end

endmodule

### rtl/divider_and_reload_timer.sv
// ----------------------------------------------------------------------------
// divider_and_reload_timer: console divider / reload counter timer
// Ticks, bus reads and bus writes to the divider, counter, modulo and control
// registers; one result transfer per input transfer.
// ----------------------------------------------------------------------------
// A read, a write, an unused opcode or a tick with the counter disabled loads
// its result into the output register when accepted. A tick with the counter
// enabled adds the tick cycles to the held counter prescale and then steps:
// a single compare-and-subtract unit makes one counter step per cycle while
// the sum reaches the selected period, and the remainder is kept as the new
// prescale. The input is stalled while a tick is stepping and while an
// undelivered result blocks the output register.
module divider_and_reload_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_cycles,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_timer_irq
);
    import drt_pkg::*;

    t_state              r_state, n_state;
    logic [7:0]          r_div_pre, n_div_pre;
    logic [7:0]          r_div, n_div;
    logic [9:0]          r_cnt_pre, n_cnt_pre;
    logic [7:0]          r_cnt, n_cnt;
    logic [7:0]          r_tma, n_tma;
    logic                r_en, n_en;
    logic [1:0]          r_sel, n_sel;
    logic [CACC_W-1:0]   r_cacc, n_cacc;
    logic                r_irq, n_irq;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_rd, n_rd;
    logic                r_out_irq, n_out_irq;

    logic                out_free;
    logic                accept;
    logic [8:0]          div_acc;
    logic [CACC_W-1:0]   period;
    t_step               step;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign div_acc  = {1'b0, r_div_pre} + {1'b0, i_cycles};
    assign period   = rate_period(r_sel);

    drt_step u_step (
        .i_cacc    (r_cacc),
        .i_period  (period),
        .i_counter (r_cnt),
        .i_reload  (r_tma),
        .o_step    (step)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == OP_TICK && r_en) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!step.ge && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_in_stall  = !(r_state == ST_IDLE && out_free);
        n_div_pre   = r_div_pre;
        n_div       = r_div;
        n_cnt_pre   = r_cnt_pre;
        n_cnt       = r_cnt;
        n_tma       = r_tma;
        n_en        = r_en;
        n_sel       = r_sel;
        n_cacc      = r_cacc;
        n_irq       = r_irq;
        n_rd        = r_rd;
        n_out_irq   = r_out_irq;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_opcode == OP_TICK) begin
                        n_div_pre = div_acc[7:0];
                        if (div_acc[8]) begin
                            n_div = r_div + 8'd1;
                        end
                        if (r_en) begin
                            n_cacc = {1'b0, r_cnt_pre} + CACC_W'(i_cycles);
                            n_irq  = 1'b0;
                        end else begin
                            n_out_valid = 1'b1;
                            n_rd        = 8'd0;
                            n_out_irq   = 1'b0;
                        end
                    end else if (i_opcode == OP_READ) begin
                        n_out_valid = 1'b1;
                        n_out_irq   = 1'b0;
                        priority if (i_address == ADDR_DIV) begin
                            n_rd = r_div;
                        end else if (i_address == ADDR_TIMA) begin
                            n_rd = r_cnt;
                        end else if (i_address == ADDR_TMA) begin
                            n_rd = r_tma;
                        end else if (i_address == ADDR_TAC) begin
                            n_rd = TAC_READ_BASE | {5'd0, r_en, r_sel};
                        end else begin
                            n_rd = UNMAPPED_READ;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_rd        = 8'd0;
                        n_out_irq   = 1'b0;
                        if (i_opcode == OP_WRITE) begin
                            // unmapped writes fall through untouched
                            if (i_address == ADDR_DIV) begin
                                n_div = 8'd0;
                            end else if (i_address == ADDR_TIMA) begin
                                n_cnt = i_write_data;
                            end else if (i_address == ADDR_TMA) begin
                                n_tma = i_write_data;
                            end else if (i_address == ADDR_TAC) begin
                                n_en  = i_write_data[TAC_ENABLE_POS];
                                n_sel = i_write_data[1:0];
                            end
                        end
                    end
                end
            end
            ST_RUN: begin
                if (step.ge) begin
                    n_cacc = step.cacc_next;
                    n_cnt  = step.counter_next;
                    n_irq  = r_irq | step.wrap;
                end else if (out_free) begin
                    n_cnt_pre   = r_cacc[9:0];
                    n_out_valid = 1'b1;
                    n_rd        = 8'd0;
                    n_out_irq   = r_irq;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_pre   <= '0;
            r_div       <= '0;
            r_cnt_pre   <= '0;
            r_cnt       <= '0;
            r_tma       <= '0;
            r_en        <= 1'b0;
            r_sel       <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_pre   <= n_div_pre;
            r_div       <= n_div;
            r_cnt_pre   <= n_cnt_pre;
            r_cnt       <= n_cnt;
            r_tma       <= n_tma;
            r_en        <= n_en;
            r_sel       <= n_sel;
            r_irq       <= n_irq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cacc    <= n_cacc;
        r_rd      <= n_rd;
        r_out_irq <= n_out_irq;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rd;
    assign o_timer_irq = r_out_irq;

endmodule
